FILE: sv/lbw_pkg.sv
`timescale 1ns / 1ps
package lbw_pkg;

  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 128;
  localparam int NDIR       = 5;

  // item kinds
  localparam logic [2:0] KIND_SPEED = 3'd0;
  localparam logic [2:0] KIND_DRIVE = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_STEP  = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic signed [35:0] S32_MAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] S32_MIN = 36'shF80000000;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_STEP, ST_SDRAIN, ST_CLEAR, ST_READ, ST_RDRAIN, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_STEP, OP_READ, OP_ZERO, OP_INIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_item;
    logic flip;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic       scan_last;
    logic       pipe_idle;
    logic [2:0] kind;
    logic       in_grid;
  } status_t;

  // clip to 32-bit signed, msb flags a clip
  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    logic [32:0] r;
    if (v > S32_MAX) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < S32_MIN) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

FILE: sv/lbw_datapath.sv
`timescale 1ns / 1ps
module lbw_datapath import lbw_pkg::*; #(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [2:0]         kind,
  input  logic [7:0]         cell_x,
  input  logic [6:0]         cell_y,
  input  logic [15:0]        speed_sq,
  input  logic signed [31:0] drive,
  output logic signed [31:0] density,
  output logic               saturated
);

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int YDEP  = 2 ** YW;
  localparam logic [XW-1:0] X_LAST = XW'(GRID_X - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(GRID_Y - 1);

  logic [XW-1:0] x_in, item_x, cnt_x, xm, xp;
  logic [YW-1:0] y_in, item_y, cnt_y, ym, yp;
  logic          x_ok, y_ok, scan_issue;
  logic [AW-1:0] ra [NDIR];
  logic          bank;

  // memories
  logic [15:0]        spd_mem [DEPTH];
  logic [31:0]        drv_mem [YDEP];
  logic [31:0]        rd_f [NDIR];
  logic [15:0]        rd_spd;
  logic signed [31:0] rd_drv;

  // pipeline
  logic               v1, v2, v3;
  op_t                op1;
  logic               x0_1;
  logic [AW-1:0]      wa1, wa2, wa3;
  logic signed [31:0] rho2, rho3;
  logic signed [32:0] jx2, jy2, jx3, jy3;
  logic signed [31:0] f2r [NDIR];
  logic signed [31:0] f3r [NDIR];
  logic [15:0]        spd2;
  logic signed [48:0] prod3;

  logic signed [35:0] sum_w;
  logic [32:0]        sum_sat;
  logic signed [31:0] p;
  logic signed [35:0] e_p, e_rho;
  logic [32:0]        fn_sat [NDIR];
  logic               fn_clip;

  logic               wr_en;
  logic [AW:0]        wr_addr;
  logic [31:0]        wr_data [NDIR];

  logic signed [31:0] res_density;
  logic               res_sat;

  // item decode
  assign x_in = XW'(cell_x);
  assign y_in = YW'(cell_y);
  assign x_ok = int'(cell_x) < GRID_X;
  assign y_ok = int'(cell_y) < GRID_Y;

  assign status.kind      = kind;
  assign status.in_grid   = x_ok && y_ok;
  assign status.scan_last = (cnt_x == X_LAST) && (cnt_y == Y_LAST);
  assign status.pipe_idle = !(v1 || v2 || v3);

  assign scan_issue = (cmd.op == OP_STEP) || (cmd.op == OP_ZERO) || (cmd.op == OP_INIT);

  // latched item coordinates
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_x <= x_in;
      item_y <= y_in;
    end
  end

  // cell scan counters, column-major with rows inner
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_x <= '0;
      cnt_y <= '0;
    end else if (scan_issue) begin
      if (cnt_y == Y_LAST) begin
        cnt_y <= '0;
        cnt_x <= (cnt_x == X_LAST) ? '0 : cnt_x + 1'b1;
      end else begin
        cnt_y <= cnt_y + 1'b1;
      end
    end
  end

  // upstream neighbors with wraparound
  always_comb begin
    xm = (cnt_x == '0) ? X_LAST : cnt_x - 1'b1;
    xp = (cnt_x == X_LAST) ? '0 : cnt_x + 1'b1;
    ym = (cnt_y == '0) ? Y_LAST : cnt_y - 1'b1;
    yp = (cnt_y == Y_LAST) ? '0 : cnt_y + 1'b1;
    if (cmd.op == OP_READ) begin
      for (int d = 0; d < NDIR; d++) ra[d] = {item_x, item_y};
    end else begin
      ra[0] = {cnt_x, cnt_y};
      ra[1] = {xm, cnt_y};
      ra[2] = {cnt_x, ym};
      ra[3] = {xp, cnt_y};
      ra[4] = {cnt_x, yp};
    end
  end

  // ping-pong banks of collided distributions, one memory per direction
  for (genvar d = 0; d < NDIR; d++) begin : g_dir
    logic [31:0] mem [2 * DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en) mem[wr_addr] <= wr_data[d];
      rd_f[d] <= mem[{bank, ra[d]}];
    end
  end

  // speed table
  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) spd_mem[{cnt_x, cnt_y}] <= '0;
    else if (cmd.load_item && kind == KIND_SPEED && x_ok && y_ok)
      spd_mem[{x_in, y_in}] <= speed_sq;
    rd_spd <= spd_mem[ra[0]];
  end

  // drive table
  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) drv_mem[cnt_y] <= '0;
    else if (cmd.load_item && kind == KIND_DRIVE && y_ok) drv_mem[y_in] <= drive;
    rd_drv <= drv_mem[cnt_y];
  end

  // stage 1 tags
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= (cmd.op == OP_STEP) || (cmd.op == OP_READ);
    op1  <= cmd.op;
    wa1  <= {cnt_x, cnt_y};
    x0_1 <= (cnt_x == '0);
  end

  // density sum
  always_comb begin
    sum_w = '0;
    for (int d = 0; d < NDIR; d++) sum_w = sum_w + 36'($signed(rd_f[d]));
    sum_sat = sat32(sum_w);
  end

  // stage 2: density and momenta
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1 && (op1 == OP_STEP);
    rho2 <= x0_1 ? rd_drv : $signed(sum_sat[31:0]);
    jx2  <= 33'($signed(rd_f[1])) - 33'($signed(rd_f[3]));
    jy2  <= 33'($signed(rd_f[2])) - 33'($signed(rd_f[4]));
    for (int d = 0; d < NDIR; d++) f2r[d] <= $signed(rd_f[d]);
    spd2 <= rd_spd;
    wa2  <= wa1;
  end

  // stage 3: pressure product
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    prod3 <= rho2 * $signed({1'b0, spd2});
    rho3  <= rho2;
    jx3   <= jx2;
    jy3   <= jy2;
    for (int d = 0; d < NDIR; d++) f3r[d] <= f2r[d];
    wa3   <= wa2;
  end

  // stage 4: collision with floor shift and clipping
  always_comb begin
    p         = prod3[47:16];
    e_p       = 36'(p);
    e_rho     = 36'(rho3);
    fn_sat[0] = sat32((e_rho <<< 1) - (e_p <<< 2) - 36'(f3r[0]));
    fn_sat[1] = sat32(e_p + 36'(jx3) - 36'(f3r[1]));
    fn_sat[2] = sat32(e_p + 36'(jy3) - 36'(f3r[2]));
    fn_sat[3] = sat32(e_p - 36'(jx3) - 36'(f3r[3]));
    fn_sat[4] = sat32(e_p - 36'(jy3) - 36'(f3r[4]));
    fn_clip   = 1'b0;
    for (int d = 0; d < NDIR; d++) fn_clip = fn_clip | fn_sat[d][32];
  end

  // shared write port: collided results to the idle bank, or zero sweep
  always_comb begin
    if (v3) begin
      wr_en   = 1'b1;
      wr_addr = {~bank, wa3};
      for (int d = 0; d < NDIR; d++) wr_data[d] = fn_sat[d][31:0];
    end else begin
      wr_en   = (cmd.op == OP_ZERO) || (cmd.op == OP_INIT);
      wr_addr = {bank, cnt_x, cnt_y};
      for (int d = 0; d < NDIR; d++) wr_data[d] = '0;
    end
  end

  // bank select
  always_ff @(posedge clk) begin
    if (rst) bank <= 1'b0;
    else if (cmd.flip) bank <= ~bank;
  end

  // per-item result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_density <= '0;
      res_sat     <= 1'b0;
    end else if (cmd.load_item) begin
      res_density <= '0;
      res_sat     <= 1'b0;
    end else begin
      if (v1 && op1 == OP_READ) res_density <= $signed(sum_sat[31:0]);
      res_sat <= res_sat | (v1 && sum_sat[32]) | (v3 && fn_clip);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      density   <= res_density;
      saturated <= res_sat;
    end
  end

endmodule

FILE: sv/lbw_ctrl.sv
`timescale 1ns / 1ps
module lbw_ctrl import lbw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   accept, out_free;

  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (status.scan_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (status.kind == KIND_STEP) state_next = ST_STEP;
          else if (status.kind == KIND_CLEAR) state_next = ST_CLEAR;
          else if (status.kind == KIND_READ && status.in_grid) state_next = ST_READ;
          else state_next = ST_DONE;
        end
      end
      ST_STEP:   if (status.scan_last) state_next = ST_SDRAIN;
      ST_SDRAIN: if (status.pipe_idle) state_next = ST_DONE;
      ST_CLEAR:  if (status.scan_last) state_next = ST_DONE;
      ST_READ:   state_next = ST_RDRAIN;
      ST_RDRAIN: if (status.pipe_idle) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.load_item = accept;
    in_ready      = (state == ST_IDLE);
    unique case (state)
      ST_INIT:   cmd.op = OP_INIT;
      ST_STEP:   cmd.op = OP_STEP;
      ST_CLEAR:  cmd.op = OP_ZERO;
      ST_READ:   cmd.op = OP_READ;
      ST_SDRAIN: cmd.flip = status.pipe_idle;
      ST_DONE:   cmd.load_out = out_free;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= cmd.load_out | (out_valid & ~out_ready);
  end

endmodule

FILE: sv/lattice_boltzmann_wave_grid.sv
`timescale 1ns / 1ps
// channel | signals                                        | beat
// in      | in_valid, in_ready, kind, cell_x, cell_y,      | one command
//         | speed_sq, drive                                |
// out     | out_valid, out_ready, density, saturated       | one result
//
// step: accept, a scan of every cell, a drain of the pipeline, then the result,
// one cell a cycle through one read and one write port per direction memory.
// clear: a zero sweep over every cell; read: one lookup and a drain; others: accept and result.
// after reset a sweep zeroes the speed and drive tables and the current bank, in_ready low.
// a held result beat stalls the next one but a new command is still taken.
module lattice_boltzmann_wave_grid import lbw_pkg::*; #(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [7:0]         cell_x,
  input  logic [6:0]         cell_y,
  input  logic [15:0]        speed_sq,
  input  logic signed [31:0] drive,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] density,
  output logic               saturated
);

  cmd_t    cmd;
  status_t status;

  lbw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lbw_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (kind),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .speed_sq  (speed_sq),
    .drive     (drive),
    .density   (density),
    .saturated (saturated)
  );

endmodule

FILE: sv/lbw_checker.sv
`timescale 1ns / 1ps
module lbw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] density,
  input logic        saturated
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(density) && $stable(saturated))
    else $error("result beat changed while stalled");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // a result appears as the block returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result beat without return to idle");

endmodule

bind lattice_boltzmann_wave_grid lbw_checker u_lbw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .density   (density),
  .saturated (saturated)
);

FILE: dv/tb_lattice_boltzmann_wave_grid.sv
`timescale 1ns / 1ps
module tb_lattice_boltzmann_wave_grid;
  import lbw_pkg::*;

  // small grid keeps a step to a scan of GX*GY cells
  localparam int GX = 8;
  localparam int GY = 4;
  localparam int NCELLS = GX * GY;
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         kind;
  logic [7:0]         cell_x;
  logic [6:0]         cell_y;
  logic [15:0]        speed_sq;
  logic signed [31:0] drive;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] density;
  logic               saturated;

  lattice_boltzmann_wave_grid #(.GRID_X(GX), .GRID_Y(GY)) dut (.*);

  // model state
  logic signed [31:0] flow_f [NCELLS*NDIR];
  logic signed [31:0] coll_f [NCELLS*NDIR];
  logic [15:0]        wave_speed [NCELLS];
  logic signed [31:0] row_drive [GY];
  logic               clipped;
  int                 vel_x [NDIR] = '{0, 1, 0, -1, 0};
  int                 vel_y [NDIR] = '{0, 0, 1, 0, -1};

  typedef struct {
    logic signed [31:0] dens;
    logic               sat;
  } density_beat_t;

  density_beat_t pending_density [$];
  int            error_count;
  int            send_idle_pct;
  int            recv_idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #4ms;
    $display("tb_lattice_boltzmann_wave_grid: FAIL");
    $finish;
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > LIM_HI) begin
      clipped = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < LIM_LO) begin
      clipped = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] cell_total(bit use_coll, int c);
    longint s;
    s = 0;
    for (int i = 0; i < NDIR; i++)
      s += use_coll ? longint'(coll_f[c*NDIR+i]) : longint'(flow_f[c*NDIR+i]);
    return clip32(s);
  endfunction

  // one time step: collide every cell then stream with wraparound
  task automatic advance_grid();
    longint rho, jx, jy, p;
    int c, nx, ny;
    for (int x = 0; x < GX; x++) begin
      for (int y = 0; y < GY; y++) begin
        c = x * GY + y;
        rho = longint'(cell_total(1'b0, c));
        jx = longint'(flow_f[c*NDIR+1]) - longint'(flow_f[c*NDIR+3]);
        jy = longint'(flow_f[c*NDIR+2]) - longint'(flow_f[c*NDIR+4]);
        if (x == 0) rho = longint'(row_drive[y]);
        p = (rho * longint'(wave_speed[c])) >>> 16;
        coll_f[c*NDIR] = clip32(2 * rho - 4 * p - longint'(flow_f[c*NDIR]));
        for (int i = 1; i < NDIR; i++)
          coll_f[c*NDIR+i] = clip32(p + vel_x[i] * jx + vel_y[i] * jy
                                    - longint'(flow_f[c*NDIR+i]));
      end
    end
    for (int x = 0; x < GX; x++) begin
      for (int y = 0; y < GY; y++) begin
        c = x * GY + y;
        for (int i = 0; i < NDIR; i++) begin
          nx = (x + GX + vel_x[i]) % GX;
          ny = (y + GY + vel_y[i]) % GY;
          flow_f[(nx*GY+ny)*NDIR+i] = coll_f[c*NDIR+i];
        end
      end
    end
  endtask

  task automatic predict_density(input logic [2:0] k, input logic [7:0] x,
                                 input logic [6:0] y, input logic [15:0] spd,
                                 input logic signed [31:0] drv,
                                 output density_beat_t beat);
    bit in_grid;
    in_grid = (x < GX) && (y < GY);
    clipped = 1'b0;
    beat.dens = '0;
    case (k)
      KIND_SPEED: if (in_grid) wave_speed[x*GY+y] = spd;
      KIND_DRIVE: if (y < GY) row_drive[y] = drv;
      KIND_CLEAR: begin
        foreach (flow_f[i]) flow_f[i] = '0;
        foreach (coll_f[i]) coll_f[i] = '0;
      end
      KIND_STEP: advance_grid();
      KIND_READ: if (in_grid) beat.dens = cell_total(1'b1, x*GY+y);
      default: ;
    endcase
    beat.sat = clipped;
  endtask

  // present one beat, hold until taken
  task automatic send_item(input logic [2:0] k, input logic [7:0] x,
                           input logic [6:0] y, input logic [15:0] spd,
                           input logic signed [31:0] drv);
    density_beat_t beat;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    cell_x   <= x;
    cell_y   <= y;
    speed_sq <= spd;
    drive    <= drv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_density(k, x, y, spd, drv, beat);
    pending_density.push_back(beat);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_density.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result check
  always @(posedge clk) begin
    density_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_density.size() == 0) begin
        report_mismatch("unexpected beat", density, 0);
      end else begin
        want = pending_density.pop_front();
        if (density !== want.dens) report_mismatch("density", density, want.dens);
        if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic test_directed();
    send_item(KIND_CLEAR, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_SPEED, 1, 1, 16'hFFFF, 0);
    send_item(KIND_SPEED, 0, 3, 16'h0000, 0);
    send_item(KIND_SPEED, 8'hFF, 7'h7F, 16'h5555, 0);
    send_item(KIND_SPEED, 0, 0, 16'h4000, 0);
    send_item(KIND_DRIVE, 0, 0, 0, 32'sh7FFF_FFFF);
    send_item(KIND_DRIVE, 0, 1, 0, 32'sh8000_0000);
    send_item(KIND_DRIVE, 0, 2, 0, 32'sh0001_0000);
    send_item(KIND_DRIVE, 0, 7'h7F, 0, 32'sh1234_5678);
    send_item(KIND_STEP, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 1, 0, 0);
    send_item(KIND_READ, 1, 0, 0, 0);
    send_item(KIND_STEP, 0, 0, 0, 0);
    send_item(KIND_READ, 1, 1, 0, 0);
    send_item(KIND_READ, 8'hFF, 7'h7F, 0, 0);
    for (logic [3:0] k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_item(k[2:0], 8'hFF, 7'h7F, 16'hFFFF, 32'shFFFF_FFFF);
    wait_drained();
    send_item(KIND_STEP, 0, 0, 0, 0);
    send_item(KIND_READ, 7, 3, 0, 0);
    send_item(KIND_CLEAR, 0, 0, 0, 0);
    send_item(KIND_READ, 1, 1, 0, 0);
  endtask

  function automatic logic signed [31:0] rand_level();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic test_random(int count);
    int r;
    logic [7:0] x;
    logic [6:0] y;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, GX-1));
      y = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, GY-1));
      if (r < 20)
        send_item(KIND_SPEED, x, y, 16'($urandom), rand_level());
      else if (r < 38)
        send_item(KIND_DRIVE, 8'($urandom), y, 16'($urandom), rand_level());
      else if (r < 58)
        send_item(KIND_STEP, 8'($urandom), 7'($urandom), 16'($urandom), rand_level());
      else if (r < 92)
        send_item(KIND_READ, x, y, 16'($urandom), rand_level());
      else if (r < 95)
        send_item(KIND_CLEAR, 8'($urandom), 7'($urandom), 16'($urandom), rand_level());
      else
        send_item(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), x, y,
                  16'($urandom), rand_level());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    cell_x = '0;
    cell_y = '0;
    speed_sq = '0;
    drive = '0;
    out_ready = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (flow_f[i]) flow_f[i] = '0;
    foreach (coll_f[i]) coll_f[i] = '0;
    foreach (wave_speed[i]) wave_speed[i] = '0;
    foreach (row_drive[i]) row_drive[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    send_idle_pct = 20;
    recv_idle_pct = 64;
    test_random(25);
    send_idle_pct = 64;
    recv_idle_pct = 20;
    test_random(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(25);

    wait_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("tb_lattice_boltzmann_wave_grid: PASS");
    else
      $display("tb_lattice_boltzmann_wave_grid: FAIL");
    $finish;
  end

endmodule
